/* sv/wavhp_pkg.sv */
// Shared types and constants of the RIFF/WAVE header parser.
// No dependencies; used by every module of the block.
`default_nettype none

package wavhp_pkg;

  // Default number of leading file bytes that are parsed
  localparam int unsigned HEAD_BYTES_DEF = 4096;

  // Fixed layout of a RIFF/WAVE file
  localparam int unsigned MIN_BYTES   = 44;
  localparam int unsigned FIRST_CHUNK = 12;
  localparam int unsigned FMT_BYTES   = 16;
  localparam int unsigned RIFF_POS    = 3;
  localparam int unsigned WAVE_POS    = 11;
  localparam int unsigned HDR_LAST    = 7;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // Chunk walk position width (never moves backward)
  localparam int unsigned NCS_W = 34;

  // Frame count divider
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int unsigned BPF_W     = 29;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_SHORT   = 2'd1;
  localparam logic [1:0] STATUS_FOREIGN = 2'd2;
  localparam logic [1:0] STATUS_NO_FMT  = 2'd3;

  typedef enum logic [1:0] {
    ST_PARSE,
    ST_MUL,
    ST_DIV,
    ST_LOAD
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic step;      // item accepted: shift in the byte
    logic mul;       // form bytes per frame, arm the divider
    logic div_step;  // one quotient bit
    logic finish;    // load the result and clear for the next file
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
  } dp_sts_t;

endpackage

`default_nettype wire

/* sv/wavhp_ctrl.sv */
// Controller of the RIFF/WAVE header parser: sequencing and handshakes.
// Depends on wavhp_pkg.
`default_nettype none

module wavhp_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_end_of_file,
  output logic                 in_ready,
  input  wire                  out_ready,
  output logic                 out_valid,
  output wavhp_pkg::dp_cmd_t   cmd,
  input  wavhp_pkg::dp_sts_t   sts
);

  wavhp_pkg::ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic out_free;

  assign in_ready  = (state_r == wavhp_pkg::ST_PARSE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wavhp_pkg::ST_PARSE: begin
        if (accept && in_end_of_file) state_nxt = wavhp_pkg::ST_MUL;
      end
      wavhp_pkg::ST_MUL: begin
        state_nxt = wavhp_pkg::ST_DIV;
      end
      wavhp_pkg::ST_DIV: begin
        if (sts.div_last) state_nxt = wavhp_pkg::ST_LOAD;
      end
      wavhp_pkg::ST_LOAD: begin
        if (out_free) state_nxt = wavhp_pkg::ST_PARSE;
      end
      default: state_nxt = wavhp_pkg::ST_PARSE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    case (state_r)
      wavhp_pkg::ST_PARSE: cmd.step     = accept;
      wavhp_pkg::ST_MUL:   cmd.mul      = 1'b1;
      wavhp_pkg::ST_DIV:   cmd.div_step = 1'b1;
      wavhp_pkg::ST_LOAD:  cmd.finish   = out_free;
      default:             cmd          = '0;
    endcase
  end

  // Output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish)     out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wavhp_pkg::ST_PARSE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/wavhp_dp.sv */
// Datapath of the RIFF/WAVE header parser: byte window, chunk walk,
// fmt capture, bytes-per-frame multiply, serial divider and result register.
// Depends on wavhp_pkg.
`default_nettype none

module wavhp_dp #(
  parameter int unsigned HEAD_BYTES = wavhp_pkg::HEAD_BYTES_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wavhp_pkg::dp_cmd_t   cmd,
  output wavhp_pkg::dp_sts_t   sts,
  input  wire  [7:0]           in_file_byte,
  output logic [1:0]           out_status,
  output logic                 out_readable,
  output logic [15:0]          out_channel_count,
  output logic signed [31:0]   out_sample_rate,
  output logic [15:0]          out_sample_bits,
  output logic [31:0]          out_frame_count,
  output logic                 out_frames_valid
);

  localparam int unsigned BPW   = $clog2(HEAD_BYTES + 1);
  localparam int unsigned NCS_W = wavhp_pkg::NCS_W;
  localparam int unsigned BPF_W = wavhp_pkg::BPF_W;
  localparam int unsigned WIN_W = 8 * wavhp_pkg::FMT_BYTES;

  // Parse state
  logic [BPW-1:0]    bp_r, bp_nxt;
  logic [NCS_W-1:0]  ncs_r, ncs_nxt;
  logic [WIN_W-1:0]  win_r, win_nxt;
  logic [15:0]       due_r, due_nxt;
  logic              tags_ok_r, tags_ok_nxt;
  logic [15:0]       kept_ch_r, kept_ch_nxt;
  logic [31:0]       kept_rate_r, kept_rate_nxt;
  logic [15:0]       kept_bits_r, kept_bits_nxt;
  logic              data_seen_r, data_seen_nxt;
  logic [31:0]       data_size_r, data_size_nxt;
  logic              stopped_r, stopped_nxt;

  // Divider
  logic [BPF_W-1:0]              bpf_r;
  logic [31:0]                   quo_r, quo_nxt;
  logic [BPF_W-1:0]              rem_r, rem_nxt;
  logic [wavhp_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [BPF_W:0]                rem_try;
  logic                          rem_ge;

  // Step signals
  logic [WIN_W-1:0]  win_sh;
  logic              in_head;
  logic              hdr_hit;
  logic [31:0]       chunk_id;
  logic [31:0]       chunk_size;
  logic              is_fmt;
  logic              is_data;

  // Result
  logic              res_short;
  logic              res_readable;
  logic              res_frames_ok;

  assign in_head    = (bp_r < BPW'(HEAD_BYTES));
  assign win_sh     = {win_r[WIN_W-9:0], in_file_byte};
  assign chunk_id   = win_sh[63:32];
  assign chunk_size = {win_sh[7:0], win_sh[15:8], win_sh[23:16], win_sh[31:24]};
  assign is_fmt     = (chunk_id == wavhp_pkg::TAG_FMT);
  assign is_data    = (chunk_id == wavhp_pkg::TAG_DATA);
  assign hdr_hit    = !stopped_r &&
                      ((NCS_W + 1)'(bp_r) ==
                       ({1'b0, ncs_r} + (NCS_W + 1)'(wavhp_pkg::HDR_LAST)));

  // Parse one byte, or clear for the next file
  always_comb begin
    bp_nxt        = bp_r;
    ncs_nxt       = ncs_r;
    win_nxt       = win_r;
    due_nxt       = due_r;
    tags_ok_nxt   = tags_ok_r;
    kept_ch_nxt   = kept_ch_r;
    kept_rate_nxt = kept_rate_r;
    kept_bits_nxt = kept_bits_r;
    data_seen_nxt = data_seen_r;
    data_size_nxt = data_size_r;
    stopped_nxt   = stopped_r;
    if (cmd.finish) begin
      bp_nxt        = '0;
      ncs_nxt       = NCS_W'(wavhp_pkg::FIRST_CHUNK);
      due_nxt       = '0;
      tags_ok_nxt   = 1'b1;
      kept_ch_nxt   = '0;
      kept_rate_nxt = '0;
      kept_bits_nxt = '0;
      data_seen_nxt = 1'b0;
      data_size_nxt = '0;
      stopped_nxt   = 1'b0;
    end else if (cmd.step && in_head) begin
      win_nxt = win_sh;
      bp_nxt  = bp_r + 1'b1;
      // Complete a capture whose 16 bytes are now all in the window
      if (due_r[0]) begin
        kept_ch_nxt   = {win_sh[103:96], win_sh[111:104]};
        kept_rate_nxt = {win_sh[71:64], win_sh[79:72], win_sh[87:80], win_sh[95:88]};
        kept_bits_nxt = {win_sh[7:0], win_sh[15:8]};
      end
      due_nxt = {1'b0, due_r[15:1]};
      // Check the file tags
      if (bp_r == BPW'(wavhp_pkg::RIFF_POS) && win_sh[31:0] != wavhp_pkg::TAG_RIFF)
        tags_ok_nxt = 1'b0;
      if (bp_r == BPW'(wavhp_pkg::WAVE_POS) && win_sh[31:0] != wavhp_pkg::TAG_WAVE)
        tags_ok_nxt = 1'b0;
      // Chunk header complete: act on its id and advance the walk
      if (hdr_hit) begin
        if (is_fmt) due_nxt[15] = 1'b1;
        if (is_data) begin
          data_seen_nxt = 1'b1;
          data_size_nxt = chunk_size;
          stopped_nxt   = 1'b1;
        end else begin
          ncs_nxt = ncs_r + NCS_W'(8) + NCS_W'(chunk_size) + NCS_W'(chunk_size[0]);
          if (chunk_size == 32'd0) stopped_nxt = 1'b1;
        end
      end
    end
  end

  // Restoring divider step
  assign rem_try = {rem_r, quo_r[31]};
  assign rem_ge  = (rem_try >= {1'b0, bpf_r});

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    if (cmd.mul) begin
      quo_nxt = data_size_r;
      rem_nxt = '0;
    end else if (cmd.div_step) begin
      quo_nxt = {quo_r[30:0], rem_ge};
      rem_nxt = rem_ge ? BPF_W'(rem_try - {1'b0, bpf_r}) : rem_try[BPF_W-1:0];
    end
  end

  assign sts.div_last = (cnt_r == {wavhp_pkg::DIV_CNT_W{1'b1}});

  // Result fields
  assign res_short     = (bp_r < BPW'(wavhp_pkg::MIN_BYTES));
  assign res_readable  = (kept_ch_r != 16'd0) && (kept_rate_r != 32'd0) &&
                         !kept_rate_r[31];
  assign res_frames_ok = data_seen_r && (bpf_r != '0);

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r        <= '0;
      ncs_r       <= NCS_W'(wavhp_pkg::FIRST_CHUNK);
      due_r       <= '0;
      tags_ok_r   <= 1'b1;
      kept_ch_r   <= '0;
      kept_rate_r <= '0;
      kept_bits_r <= '0;
      data_seen_r <= 1'b0;
      data_size_r <= '0;
      stopped_r   <= 1'b0;
      cnt_r       <= '0;
    end else begin
      bp_r        <= bp_nxt;
      ncs_r       <= ncs_nxt;
      due_r       <= due_nxt;
      tags_ok_r   <= tags_ok_nxt;
      kept_ch_r   <= kept_ch_nxt;
      kept_rate_r <= kept_rate_nxt;
      kept_bits_r <= kept_bits_nxt;
      data_seen_r <= data_seen_nxt;
      data_size_r <= data_size_nxt;
      stopped_r   <= stopped_nxt;
      if (cmd.mul)           cnt_r <= '0;
      else if (cmd.div_step) cnt_r <= cnt_r + 1'b1;
    end
  end

  // Window, multiplier and divider payload
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (cmd.mul) bpf_r <= BPF_W'(kept_ch_r) * BPF_W'(kept_bits_r[15:3]);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_readable      <= 1'b0;
      out_channel_count <= '0;
      out_sample_rate   <= '0;
      out_sample_bits   <= '0;
      out_frame_count   <= '0;
      out_frames_valid  <= 1'b0;
      if (res_short) begin
        out_status <= wavhp_pkg::STATUS_SHORT;
      end else if (!tags_ok_r) begin
        out_status <= wavhp_pkg::STATUS_FOREIGN;
      end else begin
        out_status        <= res_readable ? wavhp_pkg::STATUS_OK : wavhp_pkg::STATUS_NO_FMT;
        out_readable      <= res_readable;
        out_channel_count <= kept_ch_r;
        out_sample_rate   <= kept_rate_r;
        out_sample_bits   <= kept_bits_r;
        out_frame_count   <= res_frames_ok ? quo_r : 32'd0;
        out_frames_valid  <= res_frames_ok;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/wav_header_chunk_parser_top.sv */
// RIFF/WAVE header parser top level: controller plus datapath.
// Depends on wavhp_pkg, wavhp_ctrl and wavhp_dp.
//
// Feed the file one byte per item, in file order, with in_end_of_file set on
// the final byte. Bytes are taken one per clock while in_ready is high; only
// the first HEAD_BYTES are parsed, later ones are accepted and ignored until
// the last byte. After the last byte the block forms the frame count (a
// multiply, then a one-bit-per-cycle divider, then a load that waits for a
// free output register) with in_ready low, then places one result item in
// the output register; the next file may start streaming while that result
// waits to be taken.
`default_nettype none

module wav_header_chunk_parser_top #(
  parameter int unsigned HEAD_BYTES = wavhp_pkg::HEAD_BYTES_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [7:0]          in_file_byte,
  input  wire                 in_end_of_file,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [1:0]          out_status,
  output logic                out_readable,
  output logic [15:0]         out_channel_count,
  output logic signed [31:0]  out_sample_rate,
  output logic [15:0]         out_sample_bits,
  output logic [31:0]         out_frame_count,
  output logic                out_frames_valid
);

  wavhp_pkg::dp_cmd_t cmd;
  wavhp_pkg::dp_sts_t sts;

  wavhp_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_end_of_file (in_end_of_file),
    .in_ready       (in_ready),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .cmd            (cmd),
    .sts            (sts)
  );

  wavhp_dp #(
    .HEAD_BYTES (HEAD_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_file_byte      (in_file_byte),
    .out_status        (out_status),
    .out_readable      (out_readable),
    .out_channel_count (out_channel_count),
    .out_sample_rate   (out_sample_rate),
    .out_sample_bits   (out_sample_bits),
    .out_frame_count   (out_frame_count),
    .out_frames_valid  (out_frames_valid)
  );

endmodule

`default_nettype wire

/* sv/wavhp_chk.sv */
// Port-level checks for the RIFF/WAVE header parser, bound to the top level.
// Depends on wavhp_pkg and wav_header_chunk_parser_top.
`default_nettype none

module wavhp_chk (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_ready,
  input wire [7:0]          in_file_byte,
  input wire                in_end_of_file,
  input wire                out_valid,
  input wire                out_ready,
  input wire [1:0]          out_status,
  input wire                out_readable,
  input wire [15:0]         out_channel_count,
  input wire signed [31:0]  out_sample_rate,
  input wire [15:0]         out_sample_bits,
  input wire [31:0]         out_frame_count,
  input wire                out_frames_valid
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_frame_count) && $stable(out_channel_count))
    else $error("result changed while stalled");

  // Stop taking bytes while the frame count is formed
  a_eof_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_file |=> !in_ready)
    else $error("byte taken right after end of file");

  // Readable exactly when the status says so
  a_readable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_readable == (out_status == wavhp_pkg::STATUS_OK)))
    else $error("readable flag disagrees with status");

  // Drop all fields for a short or foreign file
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == wavhp_pkg::STATUS_SHORT ||
                  out_status == wavhp_pkg::STATUS_FOREIGN) |->
      out_channel_count == 16'd0 && out_sample_rate == 32'sd0 &&
      out_sample_bits == 16'd0 && !out_frames_valid)
    else $error("fields reported for rejected file");

  // No frame count without a valid data chunk
  a_frames: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frames_valid |-> out_frame_count == 32'd0)
    else $error("frame count without data chunk");

endmodule

bind wav_header_chunk_parser_top wavhp_chk u_chk (.*);

`default_nettype wire

/* tb/testbench.sv */
// Testbench of the RIFF/WAVE header parser: streams whole files one byte per item
// and checks every result item against a behavioural parser kept in step here.
// Depends on wavhp_pkg and wav_header_chunk_parser_top.
`default_nettype none

module testbench;

  localparam int unsigned HEAD        = wavhp_pkg::HEAD_BYTES_DEF;
  localparam int          CYCLE_LIMIT = 40000;
  localparam int          DRAIN       = 40;
  localparam int          TAIL_ITEMS  = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } file_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        readable;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] frames;
    logic        frames_ok;
  } wav_summary_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_file_byte = 8'h00;
  logic        in_end_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic        out_readable;
  logic [15:0] out_channel_count;
  logic signed [31:0] out_sample_rate;
  logic [15:0] out_sample_bits;
  logic [31:0] out_frame_count;
  logic        out_frames_valid;

  file_item_t   pending_bytes[$];
  wav_summary_t pending_results[$];
  logic [7:0]   file_buf[$];

  int   fault_count = 0;
  int   cycle_count = 0;
  logic calm = 1'b0;
  logic quiet_tail = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;

  // Parser state mirrored from the block
  int unsigned head_pos;
  logic [33:0] walk_start;
  logic [63:0] win_lo, win_hi;
  logic [15:0] fmt_due;
  logic        tags_ok, data_found, walk_done;
  logic [15:0] kept_ch, kept_bits;
  logic [31:0] kept_rate, data_len;

  wav_header_chunk_parser_top #(.HEAD_BYTES(HEAD)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_file_byte(in_file_byte), .in_end_of_file(in_end_of_file),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_readable(out_readable),
    .out_channel_count(out_channel_count), .out_sample_rate(out_sample_rate),
    .out_sample_bits(out_sample_bits), .out_frame_count(out_frame_count),
    .out_frames_valid(out_frames_valid)
  );

  always #5 clk = ~clk;

  task automatic clear_parser;
    head_pos   = 0;
    walk_start = 34'(wavhp_pkg::FIRST_CHUNK);
    win_lo     = '0;
    win_hi     = '0;
    fmt_due    = '0;
    tags_ok    = 1'b1;
    kept_ch    = '0;
    kept_rate  = '0;
    kept_bits  = '0;
    data_found = 1'b0;
    data_len   = '0;
    walk_done  = 1'b0;
  endtask

  // Advance the header parse by one byte; on the last byte, queue the summary
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [31:0]  id, len, bpf;
    wav_summary_t r;
    if (head_pos < HEAD) begin
      win_hi = {win_hi[55:0], win_lo[63:56]};
      win_lo = {win_lo[55:0], b};
      // a fmt capture completes once its 16 body bytes are in the window
      if (fmt_due[0]) begin
        kept_ch   = {win_hi[39:32], win_hi[47:40]};
        kept_rate = {win_hi[7:0], win_hi[15:8], win_hi[23:16], win_hi[31:24]};
        kept_bits = {win_lo[7:0], win_lo[15:8]};
      end
      fmt_due = fmt_due >> 1;
      if (head_pos == wavhp_pkg::RIFF_POS && win_lo[31:0] != wavhp_pkg::TAG_RIFF)
        tags_ok = 1'b0;
      if (head_pos == wavhp_pkg::WAVE_POS && win_lo[31:0] != wavhp_pkg::TAG_WAVE)
        tags_ok = 1'b0;
      // chunk header complete: dispatch on its id and step to the next chunk
      if (!walk_done &&
          35'(head_pos) == 35'(walk_start) + 35'(wavhp_pkg::HDR_LAST)) begin
        id  = win_lo[63:32];
        len = {win_lo[7:0], win_lo[15:8], win_lo[23:16], win_lo[31:24]};
        if (id == wavhp_pkg::TAG_FMT) begin
          fmt_due[15] = 1'b1;
        end else if (id == wavhp_pkg::TAG_DATA) begin
          data_found = 1'b1;
          data_len   = len;
          walk_done  = 1'b1;
        end
        if (!walk_done) begin
          walk_start = walk_start + 34'd8 + 34'(len) + 34'(len[0]);
          if (len == 0) walk_done = 1'b1;
        end
      end
      head_pos++;
    end
    if (last) begin
      r = '0;
      if (head_pos < wavhp_pkg::MIN_BYTES) begin
        r.status = wavhp_pkg::STATUS_SHORT;
      end else if (!tags_ok) begin
        r.status = wavhp_pkg::STATUS_FOREIGN;
      end else begin
        bpf = 32'(kept_ch) * 32'(kept_bits >> 3);
        r.channels = kept_ch;
        r.rate     = kept_rate;
        r.bits     = kept_bits;
        r.readable = (kept_ch != 0) && (kept_rate != 0) && !kept_rate[31];
        r.status   = r.readable ? wavhp_pkg::STATUS_OK : wavhp_pkg::STATUS_NO_FMT;
        if (data_found && bpf != 0) begin
          r.frames_ok = 1'b1;
          r.frames    = data_len / bpf;
        end
      end
      pending_results = {pending_results, r};
      clear_parser();
    end
  endtask

  // File building: append to file_buf, then seal it into the item queue
  task automatic add_byte(input logic [7:0] v);
    file_buf = {file_buf, v};
  endtask

  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) add_byte(v[8*i +: 8]);
  endtask

  task automatic put_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) add_byte(t[8*i +: 8]);
  endtask

  task automatic put_chunk(input logic [31:0] t, input logic [31:0] size, input int nbody);
    put_tag(t);
    put_le(size, 4);
    for (int i = 0; i < nbody; i++) add_byte(8'($urandom));
  endtask

  task automatic put_fmt(input int size, input logic [15:0] ch, input logic [31:0] rate,
                         input logic [15:0] bits);
    logic [127:0] body;
    body = {bits, 16'($urandom), 32'($urandom), rate, ch, 16'd1};
    put_tag(wavhp_pkg::TAG_FMT);
    put_le(32'(size), 4);
    for (int i = 0; i < size; i++)
      add_byte(i < 16 ? body[8*i +: 8] : 8'($urandom));
    if (size % 2 == 1) add_byte(8'($urandom));
  endtask

  task automatic put_head;
    put_tag(wavhp_pkg::TAG_RIFF);
    put_le($urandom, 4);
    put_tag(wavhp_pkg::TAG_WAVE);
  endtask

  task automatic seal_file;
    file_item_t it;
    for (int i = 0; i < file_buf.size(); i++) begin
      it.data = file_buf[i];
      it.last = (i == file_buf.size() - 1);
      pending_bytes = {pending_bytes, it};
    end
    file_buf.delete();
  endtask

  // Stimulus, reset and end of run
  initial begin
    int          kind, n, pick, nchunks, idx, random_bytes, random_files;
    logic [15:0] ch, bits;
    logic [31:0] rate, sz;
    clear_parser();

    // one-byte file
    add_byte(8'hFF);
    seal_file();
    // canonical 44-byte file, then the same cut to 43 bytes
    for (int k = 0; k < 2; k++) begin
      put_tag(wavhp_pkg::TAG_RIFF); put_le(32'd36, 4); put_tag(wavhp_pkg::TAG_WAVE);
      put_fmt(16, 16'd2, 32'd44100, 16'd16);
      put_chunk(wavhp_pkg::TAG_DATA, 32'd4096, 0);
      if (k == 1) void'(file_buf.pop_back());
      seal_file();
    end
    // broken RIFF tag, then broken WAVE tag
    for (int k = 0; k < 2; k++) begin
      put_tag(k == 0 ? wavhp_pkg::TAG_RIFF ^ 32'h1 : wavhp_pkg::TAG_RIFF);
      put_le($urandom, 4);
      put_tag(k == 1 ? wavhp_pkg::TAG_WAVE ^ 32'h8000_0000 : wavhp_pkg::TAG_WAVE);
      put_fmt(16, 16'd1, 32'd8000, 16'd8);
      put_chunk(wavhp_pkg::TAG_DATA, 32'd100, 8);
      seal_file();
    end
    // field extremes: negative rate, so not readable, yet frames reported
    put_head();
    put_fmt(16, 16'hFFFF, 32'h8000_0000, 16'hFFFF);
    put_chunk(wavhp_pkg::TAG_DATA, 32'hFFFF_FFFF, 4);
    seal_file();
    // short fmt chunk: capture runs on into the data header and completes after the stop
    put_head();
    put_fmt(4, 16'd2, 32'd22050, 16'd16);
    put_chunk(wavhp_pkg::TAG_DATA, 32'h0001_2345, 12);
    seal_file();
    // odd chunk with pad, long fmt, then a zero-size chunk ends the walk
    put_head();
    put_chunk(32'h4C49_5354, 32'd3, 4);
    put_fmt(18, 16'd6, 32'd48000, 16'd24);
    put_chunk(32'h6A75_6E6B, 32'd0, 0);
    put_fmt(16, 16'd1, 32'd8000, 16'd8);
    put_chunk(wavhp_pkg::TAG_DATA, 32'd999, 4);
    seal_file();
    // huge chunk size throws the walk past the head
    put_head();
    put_fmt(16, 16'd1, 32'd16000, 16'd32);
    put_chunk(32'h6A75_6E6B, 32'hFFFF_FFFF, 8);
    put_chunk(wavhp_pkg::TAG_DATA, 32'd64, 8);
    seal_file();

    // random files: mostly well formed, some noise, broken tags and truncation
    random_bytes = 0;
    random_files = 0;
    while (random_bytes < 800 || random_files < 12) begin
      kind = $urandom_range(0, 19);
      if (kind < 3) begin
        n = $urandom_range(1, 80);
        repeat (n) add_byte(8'($urandom));
      end else begin
        put_head();
        nchunks = $urandom_range(0, 4);
        for (int c = 0; c < nchunks; c++) begin
          pick = $urandom_range(0, 9);
          if (pick < 5) begin
            case ($urandom_range(0, 5))
              0: ch = 16'd0;
              1: ch = 16'd1;
              2: ch = 16'd2;
              3: ch = 16'hFFFF;
              default: ch = 16'($urandom);
            endcase
            case ($urandom_range(0, 5))
              0: rate = 32'd0;
              1: rate = 32'h8000_0000;
              2: rate = 32'h7FFF_FFFF;
              3: rate = 32'd44100;
              default: rate = $urandom;
            endcase
            case ($urandom_range(0, 6))
              0: bits = 16'd8;
              1: bits = 16'd16;
              2: bits = 16'd24;
              3: bits = 16'($urandom_range(0, 7));
              4: bits = 16'hFFFF;
              default: bits = 16'($urandom);
            endcase
            case ($urandom_range(0, 5))
              0, 1, 2: n = 16;
              3: n = 18;
              4: n = $urandom_range(0, 15);
              default: n = $urandom_range(17, 40);
            endcase
            put_fmt(n, ch, rate, bits);
          end else if (pick < 9) begin
            sz = ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom_range(1, 12));
            put_chunk($urandom, sz, int'(sz) + int'(sz[0]));
          end else begin
            put_chunk($urandom, $urandom | 32'h0100_0000, $urandom_range(0, 8));
            c = nchunks;
          end
        end
        if ($urandom_range(0, 4) != 0) begin
          sz = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 4096));
          put_chunk(wavhp_pkg::TAG_DATA, sz, $urandom_range(0, 8));
        end
        // flip one bit of a tag byte
        if (kind < 6) begin
          idx = $urandom_range(0, 7);
          if (idx > 3) idx += 4;
          file_buf[idx] = file_buf[idx] ^ 8'(1 << $urandom_range(0, 7));
        end
        if (kind == 19) begin
          n = $urandom_range(1, file_buf.size());
          while (file_buf.size() > n) void'(file_buf.pop_back());
        end
      end
      random_bytes += file_buf.size();
      random_files++;
      seal_file();
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // drain: all items taken, every result seen, then watch for strays
    while (pending_bytes.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run length guard and idling mode
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 200 == 0) calm <= ($urandom_range(0, 2) == 0);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Input driver: hold each item until taken, insert idle bursts between items
  always @(posedge clk) begin : feed
    file_item_t it;
    quiet_tail <= (pending_bytes.size() < TAIL_ITEMS);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!calm && !quiet_tail && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 2);
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        it = pending_bytes.pop_front();
        in_valid       <= 1'b1;
        in_file_byte   <= it.data;
        in_end_of_file <= it.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure in short bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (!calm && !quiet_tail && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted byte, compare each accepted result item
  always @(posedge clk) begin : watch
    wav_summary_t want;
    if (rst_n) begin
      if (in_valid && in_ready) parse_byte(in_file_byte, in_end_of_file);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result item with none expected");
          fault_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fault_count++;
          end
          if (out_readable !== want.readable) begin
            $error("readable: expected %0d, got %0d", want.readable, out_readable);
            fault_count++;
          end
          if (out_channel_count !== want.channels) begin
            $error("channel_count: expected %h, got %h", want.channels, out_channel_count);
            fault_count++;
          end
          if (out_sample_rate !== want.rate) begin
            $error("sample_rate: expected %h, got %h", want.rate, out_sample_rate);
            fault_count++;
          end
          if (out_sample_bits !== want.bits) begin
            $error("sample_bits: expected %h, got %h", want.bits, out_sample_bits);
            fault_count++;
          end
          if (out_frame_count !== want.frames) begin
            $error("frame_count: expected %h, got %h", want.frames, out_frame_count);
            fault_count++;
          end
          if (out_frames_valid !== want.frames_ok) begin
            $error("frames_valid: expected %0d, got %0d", want.frames_ok, out_frames_valid);
            fault_count++;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire
